@@ rtl/core/gcl_pkg.sv @@
package gcl_pkg;

    // Default sizes of the boundary tables and of the coordinates.
    localparam int MAX_BOUNDARIES_DEF = 64;
    localparam int POS_WIDTH_DEF      = 32;

    // Fixed widths of the command and result fields.
    localparam int OP_W   = 2;
    localparam int SLOT_W = 6;
    localparam int USED_W = 7;
    localparam int CELL_W = 7;

    // Command codes.
    localparam logic [OP_W-1:0] OP_WR_X   = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_Y   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_X_USED = 1'b0;
    localparam logic REG_Y_USED = 1'b1;

    // Control part of a command token as it moves down the chain.
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic              outside;
    } gcl_ctl_t;

endpackage

@@ rtl/core/gcl_cell.sv @@
module gcl_cell
    import gcl_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF,
    parameter int CW        = 7,
    parameter int IDX       = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CW-1:0]        last_x,
    input  logic [CW-1:0]        last_y,
    input  gcl_ctl_t             ctl_in,
    input  logic [POS_WIDTH-1:0] px_in,
    input  logic [POS_WIDTH-1:0] py_in,
    input  logic [CW-1:0]        cx_in,
    input  logic [CW-1:0]        cy_in,
    output gcl_ctl_t             ctl_out,
    output logic [POS_WIDTH-1:0] px_out,
    output logic [POS_WIDTH-1:0] py_out,
    output logic [CW-1:0]        cx_out,
    output logic [CW-1:0]        cy_out
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [31:0]   IDX_32 = 32'(IDX);

    // Boundary entries held by this cell, in offset-binary form.
    logic [POS_WIDTH-1:0] ex_reg;
    logic [POS_WIDTH-1:0] ey_reg;

    gcl_ctl_t             ctl_reg;
    gcl_ctl_t             ctl_next;
    logic [POS_WIDTH-1:0] px_reg;
    logic [POS_WIDTH-1:0] py_reg;
    logic [CW-1:0]        cx_reg;
    logic [CW-1:0]        cx_next;
    logic [CW-1:0]        cy_reg;
    logic [CW-1:0]        cy_next;

    logic slot_hit;
    logic is_loc;
    logic hit_x;
    logic hit_y;
    logic low_out;
    logic high_out;

    // Decode the token that arrives from the neighbor.
    assign slot_hit = (32'(ctl_in.slot) == IDX_32);
    assign is_loc   = ctl_in.valid && (ctl_in.op == OP_LOCATE);

    // A used entry that does not exceed the coordinate adds one to the count.
    assign hit_x = is_loc && (IDX_C <= last_x) && (ex_reg <= px_in);
    assign hit_y = is_loc && (IDX_C <= last_y) && (ey_reg <= py_in);

    // The first cell checks the lower edge, the last used cell the upper edge.
    assign low_out  = (IDX == 0) && ((px_in < ex_reg) || (py_in < ey_reg));
    assign high_out = ((IDX_C == last_x) && (px_in > ex_reg))
                   || ((IDX_C == last_y) && (py_in > ey_reg));

    always_comb
    begin
        ctl_next         = ctl_in;
        ctl_next.outside = ctl_in.outside || (is_loc && (low_out || high_out));
        cx_next          = cx_in + CW'(hit_x);
        cy_next          = cy_in + CW'(hit_y);
    end

    // Boundary writes land here when the token passes the addressed cell.
    always_ff @(posedge clk)
    begin
        if (ctl_in.valid && slot_hit && (ctl_in.op == OP_WR_X))
        begin
            ex_reg <= px_in;
        end
        if (ctl_in.valid && slot_hit && (ctl_in.op == OP_WR_Y))
        begin
            ey_reg <= py_in;
        end
    end

    // Token control moves one cell per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Token payload follows along with its control.
    always_ff @(posedge clk)
    begin
        px_reg <= px_in;
        py_reg <= py_in;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
    end

    assign ctl_out = ctl_reg;
    assign px_out  = px_reg;
    assign py_out  = py_reg;
    assign cx_out  = cx_reg;
    assign cy_out  = cy_reg;

endmodule

@@ rtl/core/grid_cell_locator_core.sv @@
// Results: a locate command gives its result after it has walked every cell of
// the chain and then the result registers; boundary writes give no result.
// Throughput: one command per cycle; every command walks the chain of
// MAX_BOUNDARIES cells, one cell per cycle, so busy stays low after reset.
// Reset: asynchronous, active low; busy is high for one cycle after release,
// both used counts return to 2 and the boundary tables keep undefined contents.
module grid_cell_locator_core
    import gcl_pkg::*;
#(
    parameter int MAX_BOUNDARIES = MAX_BOUNDARIES_DEF,
    parameter int POS_WIDTH      = POS_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      opcode,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [POS_WIDTH-1:0] boundary_value,
    input  logic [POS_WIDTH-1:0] pos_x,
    input  logic [POS_WIDTH-1:0] pos_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [USED_W-1:0]    cfg_data,
    output logic                 result_valid,
    output logic [CELL_W-1:0]    cell_x,
    output logic [CELL_W-1:0]    cell_y,
    output logic                 out_of_range
);

    localparam int CNT_W = $clog2(MAX_BOUNDARIES + 1);
    localparam int CW    = (CNT_W > CELL_W) ? CNT_W : CELL_W;
    localparam int LAT   = MAX_BOUNDARIES + 1;
    localparam logic [POS_WIDTH-1:0] SIGN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    logic              busy_reg;
    logic [USED_W-1:0] x_used_reg;
    logic [USED_W-1:0] y_used_reg;

    logic accept;
    logic cmd_ok;

    logic [CW-1:0] used_x;
    logic [CW-1:0] used_y;
    logic [CW-1:0] last_x;
    logic [CW-1:0] last_y;

    gcl_ctl_t             chain_ctl [MAX_BOUNDARIES+1];
    logic [POS_WIDTH-1:0] chain_px  [MAX_BOUNDARIES+1];
    logic [POS_WIDTH-1:0] chain_py  [MAX_BOUNDARIES+1];
    logic [CW-1:0]        chain_cx  [MAX_BOUNDARIES+1];
    logic [CW-1:0]        chain_cy  [MAX_BOUNDARIES+1];

    logic          res_valid_reg;
    logic          res_valid_next;
    logic [CW-1:0] res_cx_reg;
    logic [CW-1:0] res_cy_reg;
    logic          res_out_reg;

    // Commands are taken in every cycle once reset has settled.
    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign cmd_ok    = (opcode == OP_WR_X) || (opcode == OP_WR_Y) || (opcode == OP_LOCATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Used-count registers, written over the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_used_reg <= USED_W'(2);
            y_used_reg <= USED_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_USED: x_used_reg <= cfg_data;
                REG_Y_USED: y_used_reg <= cfg_data;
                default:    x_used_reg <= x_used_reg;
            endcase
        end
    end

    // Clamp the used counts to 2..MAX_BOUNDARIES and find the last used entry.
    always_comb
    begin
        if (x_used_reg < USED_W'(2))
        begin
            used_x = CW'(2);
        end
        else if (32'(x_used_reg) > 32'(MAX_BOUNDARIES))
        begin
            used_x = CW'(MAX_BOUNDARIES);
        end
        else
        begin
            used_x = CW'(x_used_reg);
        end

        if (y_used_reg < USED_W'(2))
        begin
            used_y = CW'(2);
        end
        else if (32'(y_used_reg) > 32'(MAX_BOUNDARIES))
        begin
            used_y = CW'(MAX_BOUNDARIES);
        end
        else
        begin
            used_y = CW'(y_used_reg);
        end
    end

    assign last_x = used_x - CW'(1);
    assign last_y = used_y - CW'(1);

    // Build the token for the head of the chain; values go to offset-binary.
    always_comb
    begin
        chain_ctl[0].valid   = accept && cmd_ok;
        chain_ctl[0].op      = opcode;
        chain_ctl[0].slot    = slot;
        chain_ctl[0].outside = 1'b0;
        if (opcode == OP_LOCATE)
        begin
            chain_px[0] = pos_x ^ SIGN;
            chain_py[0] = pos_y ^ SIGN;
        end
        else
        begin
            chain_px[0] = boundary_value ^ SIGN;
            chain_py[0] = boundary_value ^ SIGN;
        end
        chain_cx[0] = '0;
        chain_cy[0] = '0;
    end

    // One cell per table entry; tokens keep their order down the chain.
    for (genvar i = 0; i < MAX_BOUNDARIES; i++)
    begin : g_cell
        gcl_cell #(
            .POS_WIDTH (POS_WIDTH),
            .CW        (CW),
            .IDX       (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .last_x  (last_x),
            .last_y  (last_y),
            .ctl_in  (chain_ctl[i]),
            .px_in   (chain_px[i]),
            .py_in   (chain_py[i]),
            .cx_in   (chain_cx[i]),
            .cy_in   (chain_cy[i]),
            .ctl_out (chain_ctl[i+1]),
            .px_out  (chain_px[i+1]),
            .py_out  (chain_py[i+1]),
            .cx_out  (chain_cx[i+1]),
            .cy_out  (chain_cy[i+1])
        );
    end

    assign res_valid_next = chain_ctl[MAX_BOUNDARIES].valid
                         && (chain_ctl[MAX_BOUNDARIES].op == OP_LOCATE);

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result fields; an out-of-range point reports zero counts.
    always_ff @(posedge clk)
    begin
        res_out_reg <= chain_ctl[MAX_BOUNDARIES].outside;
        if (chain_ctl[MAX_BOUNDARIES].outside)
        begin
            res_cx_reg <= '0;
            res_cy_reg <= '0;
        end
        else
        begin
            res_cx_reg <= chain_cx[MAX_BOUNDARIES];
            res_cy_reg <= chain_cy[MAX_BOUNDARIES];
        end
    end

    assign result_valid = res_valid_reg;
    assign cell_x       = res_cx_reg[CELL_W-1:0];
    assign cell_y       = res_cy_reg[CELL_W-1:0];
    assign out_of_range = res_out_reg;

`ifndef NO_ASSERTIONS
    // A result appears only for a locate command taken earlier that has passed the whole chain.
    a_result_has_cmd: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && (opcode == OP_LOCATE), LAT)
    ) else $error("result without a matching locate command");

    // A point inside the grid lies at or above the first boundary of each axis.
    a_inside_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !out_of_range) |-> ((res_cx_reg != '0) && (res_cy_reg != '0))
    ) else $error("in-range point with an empty cell count");

    // An out-of-range result carries zero counts.
    a_outside_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && out_of_range) |-> ((cell_x == '0) && (cell_y == '0))
    ) else $error("out-of-range result with nonzero counts");

    // Once ready after reset, the block stays ready.
    a_busy_stays_low: assert property (
        @(posedge clk) disable iff (!rst_n)
        !busy |=> !busy
    ) else $error("busy rose after reset");
`endif

endmodule
